// File: rtl/core/set_assoc_lru_cache_model_core_assert.svh
// Assertion helpers shared by the cache core.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SALC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache core check failed");

// Next-cycle implication.
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache core check failed");

`endif

// File: rtl/core/salc_pkg.sv
`timescale 1ns / 1ps
package salc_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } salc_state_t;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS        = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [2:0]  rank;
  } line_t;

endpackage

// File: rtl/core/salc_if.sv
`timescale 1ns / 1ps
interface salc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] address;
  logic [1:0]  operation;
  modport source (output valid, output address, output operation, input ready);
  modport sink (input valid, input address, input operation, output ready);
endinterface

interface salc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic        second_hit;
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] eviction_count;
  modport source (output valid, output outcome, output second_hit, output hit_count,
                  output miss_count, output eviction_count, input ready);
  modport sink (input valid, input outcome, input second_hit, input hit_count,
                input miss_count, input eviction_count, output ready);
endinterface

// File: rtl/core/set_assoc_lru_cache_model_core.sv
`timescale 1ns / 1ps
// Set-associative cache model with LRU replacement and hit/miss/eviction counters.
// Input channel in_s carries one access item: a byte address and an operation
// (load, store, modify). Output channel out_s returns one result item per input:
// the outcome of the first access, a flag for the second access of a modify, and
// the saturating hit, miss and eviction totals after the access.
// Each set is one row of a synchronous memory (all ways side by side). An item is
// taken in IDLE and its set row is read into a register; in the LOOKUP state that
// follows, the row is checked, updated and written back while the result register
// is loaded. No new item is taken in LOOKUP: the single read-modify-write of the
// set row keeps the block from overlapping items.
// A modify's second access always hits and leaves the row unchanged.
// After reset the block sweeps all 2**MAX_SET_BITS rows to zero, one row a cycle,
// and takes no item until the sweep ends; configuration writes are taken anytime.
// A stalled receiver holds the result register; no new item is taken until the
// pending result is taken (or is taken in the same cycle).
module set_assoc_lru_cache_model_core
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_wdata,
  salc_in_if.sink           in_s,
  salc_out_if.source        out_s
);

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_CAP  = ((MAX_WAYS - 1) < 7) ? (MAX_WAYS - 1) : 7;

  // Configuration.
  logic [3:0] cfg_set_r;
  logic [5:0] cfg_off_r;
  logic [3:0] cfg_ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_set_r  <= 4'd4;
      cfg_off_r  <= 6'd4;
      cfg_ways_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    cfg_set_r  <= cfg_wdata[3:0];
        CFG_OFFSET_BITS: cfg_off_r  <= cfg_wdata;
        CFG_WAYS:        cfg_ways_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  logic [3:0] set_bits;
  logic [4:0] nways;
  logic [6:0] tshift;
  logic [63:0] shifted;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] in_set;
  logic [63:0] in_tag;

  always_comb begin
    set_bits = (cfg_set_r > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : cfg_set_r;
    if (cfg_ways_r == 4'd0) begin
      nways = 5'd1;
    end else if ({1'b0, cfg_ways_r} > 5'(MAX_WAYS)) begin
      nways = 5'(MAX_WAYS);
    end else begin
      nways = {1'b0, cfg_ways_r};
    end
    shifted = in_s.address >> cfg_off_r;
    for (int j = 0; j < SET_W; j++) begin
      set_mask[j] = (4'(j) < set_bits);
    end
    in_set = shifted[SET_W-1:0] & set_mask;
    tshift = {1'b0, cfg_off_r} + {3'b000, set_bits};
    in_tag = tshift[6] ? 64'd0 : (in_s.address >> tshift[5:0]);
  end

  // Control.
  salc_state_t state_r, state_nxt;
  logic [SET_W-1:0] clr_r;
  logic [SET_W-1:0] set_r;
  logic [63:0] tag_r;
  logic        mod_r;
  logic        in_ready;
  logic        accept;
  logic        mem_we;
  logic [SET_W-1:0] mem_waddr;
  line_t [MAX_WAYS-1:0] mem_wdata;
  line_t [MAX_WAYS-1:0] row_new;
  line_t [MAX_WAYS-1:0] rd_r;
  logic out_valid_r;

  assign accept = in_s.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == {SET_W{1'b1}}) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = set_r;
    mem_wdata = row_new;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      ST_IDLE:   in_ready = !out_valid_r || out_s.ready;
      ST_LOOKUP: mem_we = 1'b1;
      default: ;
    endcase
  end

  assign in_s.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= in_set;
      tag_r <= in_tag;
      mod_r <= (in_s.operation == OP_MODIFY);
    end
  end

  // Set memory: one row per set, one read and one write port.
  line_t [MAX_WAYS-1:0] mem [NUM_SETS];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rd_r <= mem[in_set];
  end

  // Lookup and LRU update on the row just read.
  logic [MAX_WAYS-1:0] en;
  logic hit_any, inv_any;
  logic [WAY_W-1:0] hit_w, inv_w, vic_w, sel_w;
  logic [2:0] best;
  logic [3:0] old_rank;

  always_comb begin
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_w   = '0;
    inv_w   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      en[i] = (5'(i) < nways);
      if (en[i] && rd_r[i].valid && (rd_r[i].tag == tag_r)) begin
        hit_any = 1'b1;
        hit_w   = WAY_W'(i);
      end
      if (en[i] && !rd_r[i].valid) begin
        inv_any = 1'b1;
        inv_w   = WAY_W'(i);
      end
    end
    // Among equal highest ranks the lowest way wins.
    vic_w = '0;
    best  = rd_r[0].rank;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (en[i] && (rd_r[i].rank > best)) begin
        best  = rd_r[i].rank;
        vic_w = WAY_W'(i);
      end
    end
    sel_w = hit_any ? hit_w : (inv_any ? inv_w : vic_w);
    old_rank = rd_r[sel_w].valid ? {1'b0, rd_r[sel_w].rank} : 4'hF;
    row_new = rd_r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (en[i] && (WAY_W'(i) != sel_w) && rd_r[i].valid &&
          ({1'b0, rd_r[i].rank} < old_rank) && (rd_r[i].rank < 3'(RANK_CAP))) begin
        row_new[i].rank = rd_r[i].rank + 3'd1;
      end
    end
    row_new[sel_w].rank  = 3'd0;
    row_new[sel_w].valid = 1'b1;
    if (!hit_any) row_new[sel_w].tag = tag_r;
  end

  // Counters and result register.
  logic [31:0] hits_r, miss_r, evict_r;
  logic [1:0]  outcome_r;
  logic        second_r;
  logic [32:0] hit_sum, miss_sum, evict_sum;

  always_comb begin
    hit_sum   = {1'b0, hits_r} + {31'd0, hit_any, 1'b0} / 33'd2 + {32'd0, mod_r};
    miss_sum  = {1'b0, miss_r} + {32'd0, !hit_any};
    evict_sum = {1'b0, evict_r} + {32'd0, !hit_any && !inv_any};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      miss_r      <= '0;
      evict_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_s.ready) out_valid_r <= 1'b0;
      if (state_r == ST_LOOKUP) begin
        out_valid_r <= 1'b1;
        hits_r  <= hit_sum[32] ? 32'hFFFF_FFFF : hit_sum[31:0];
        miss_r  <= miss_sum[32] ? 32'hFFFF_FFFF : miss_sum[31:0];
        evict_r <= evict_sum[32] ? 32'hFFFF_FFFF : evict_sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP) begin
      outcome_r <= hit_any ? OUT_HIT : (inv_any ? OUT_FILL : OUT_EVICT);
      second_r  <= mod_r;
    end
  end

  assign out_s.valid          = out_valid_r;
  assign out_s.outcome        = outcome_r;
  assign out_s.second_hit     = second_r;
  assign out_s.hit_count      = hits_r;
  assign out_s.miss_count     = miss_r;
  assign out_s.eviction_count = evict_r;

`include "set_assoc_lru_cache_model_core_assert.svh"

  `SALC_ASSERT_NEXT(a_accept_to_lookup, accept, state_r == ST_LOOKUP)
  `SALC_ASSERT_NEXT(a_lookup_gives_result, state_r == ST_LOOKUP, out_valid_r)
  `SALC_ASSERT_NOW(a_write_when_busy, mem_we, state_r == ST_LOOKUP || state_r == ST_CLEAR)
  `SALC_ASSERT_NOW(a_evict_le_miss, 1'b1, evict_r <= miss_r)

endmodule
